// ----- rtl/ecpa_pkg.sv -----
package ecpa_pkg;

  localparam int REG_CURVE_A = 0;
  localparam int REG_CURVE_B = 1;
  localparam int REG_FIELD_PRIME = 2;
  localparam int CFG_INDEX_BITS = 2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_MOV,
    OP_INV
  } op_t;

  // register file addresses
  typedef enum logic [3:0] {
    R_XP, R_YP, R_XQ, R_YQ, R_A, R_B, R_T0, R_T1,
    R_T2, R_T3, R_LAM, R_XR, R_YR, R_ONE, R_K2, R_K3
  } rsel_t;

  typedef struct packed {
    logic  start;
    op_t   op;
    rsel_t dst;
    rsel_t src_a;
    rsel_t src_b;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic bad_prime;
    logic same_x;
    logic same_y;
    logic yp_zero;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/ecpa_modmul.sv -----
module ecpa_modmul import ecpa_pkg::*; #(
  parameter int FIELD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [FIELD_BITS-1:0] a,
  input  logic [FIELD_BITS-1:0] b,
  input  logic [FIELD_BITS-1:0] m,
  output logic                  busy,
  output logic [FIELD_BITS-1:0] result
);

  localparam int CNT_BITS = $clog2(FIELD_BITS + 1);

  logic [FIELD_BITS-1:0] acc;
  logic [FIELD_BITS-1:0] opa;
  logic [FIELD_BITS-1:0] opb;
  logic [CNT_BITS-1:0]   cnt;
  logic [FIELD_BITS:0]   dbl;
  logic [FIELD_BITS-1:0] dbl_r;
  logic [FIELD_BITS:0]   addv;
  logic [FIELD_BITS-1:0] acc_next;

  // one bit of the multiplier per cycle, msb first
  always_comb begin
    dbl = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, m}) ? FIELD_BITS'(dbl - {1'b0, m}) : dbl[FIELD_BITS-1:0];
    addv = {1'b0, dbl_r} + {1'b0, opa};
    if (opb[FIELD_BITS-1]) begin
      acc_next = (addv >= {1'b0, m}) ? FIELD_BITS'(addv - {1'b0, m}) : addv[FIELD_BITS-1:0];
    end else begin
      acc_next = dbl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_BITS'(FIELD_BITS);
      acc <= '0;
      opa <= a;
      opb <= b;
    end else if (busy) begin
      acc <= acc_next;
      opb <= opb << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign result = acc;

endmodule

// ----- rtl/ecpa_datapath.sv -----
module ecpa_datapath import ecpa_pkg::*; #(
  parameter int FIELD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic [FIELD_BITS-1:0] in_px,
  input  logic [FIELD_BITS-1:0] in_py,
  input  logic [FIELD_BITS-1:0] in_qx,
  input  logic [FIELD_BITS-1:0] in_qy,
  input  logic [FIELD_BITS-1:0] cfg_a,
  input  logic [FIELD_BITS-1:0] cfg_b,
  input  logic [FIELD_BITS-1:0] cfg_p,
  output dp_status_t            status,
  output logic [FIELD_BITS-1:0] res_x,
  output logic [FIELD_BITS-1:0] res_y
);

  localparam int CNT_BITS = $clog2(FIELD_BITS + 1);
  localparam int RED_BITS = $clog2(FIELD_BITS + 1);
  localparam int NREG = 16;

  logic [FIELD_BITS-1:0] rf [NREG];
  logic [FIELD_BITS-1:0] va;
  logic [FIELD_BITS-1:0] vb;
  logic [FIELD_BITS-1:0] m;
  rsel_t                 dst;

  // multiplier
  logic                  mul_start;
  logic [FIELD_BITS-1:0] mul_a;
  logic [FIELD_BITS-1:0] mul_b;
  logic                  mul_busy;
  logic [FIELD_BITS-1:0] mul_res;

  // inversion by square and multiply, exponent p-2
  logic                  inv_run;
  logic                  inv_sq;
  logic                  inv_wait;
  logic [FIELD_BITS-1:0] inv_base;
  logic [FIELD_BITS-1:0] inv_r;
  logic [FIELD_BITS-1:0] inv_e;
  logic [CNT_BITS-1:0]   inv_cnt;

  // reduction of inputs by restoring subtraction, one shift per cycle
  logic                  red_run;
  logic [RED_BITS-1:0]   red_cnt;
  logic [FIELD_BITS-1:0] red_v [6];
  logic [FIELD_BITS-1:0] red_n [6];
  logic                  mul_wait;

  logic [FIELD_BITS:0]   sum;
  logic [FIELD_BITS-1:0] addm;
  logic [FIELD_BITS-1:0] subm;

  ecpa_modmul #(.FIELD_BITS(FIELD_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .m(m),
    .busy(mul_busy), .result(mul_res)
  );

  assign va = rf[cmd.src_a];
  assign vb = rf[cmd.src_b];
  assign sum = {1'b0, va} + {1'b0, vb};
  assign addm = (sum >= {1'b0, m}) ? FIELD_BITS'(sum - {1'b0, m}) : sum[FIELD_BITS-1:0];
  assign subm = (va >= vb) ? va - vb : FIELD_BITS'({1'b0, va} + {1'b0, m} - {1'b0, vb});

  // shifted modulus for restoring reduction step
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      logic [2*FIELD_BITS-1:0] sh;
      sh = {{FIELD_BITS{1'b0}}, m} << (red_cnt - 1'b1);
      red_n[k] = ({{FIELD_BITS{1'b0}}, red_v[k]} >= sh) ? FIELD_BITS'(
        {{FIELD_BITS{1'b0}}, red_v[k]} - sh) : red_v[k];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a = va;
    mul_b = vb;
    if (cmd.start && cmd.op == OP_MUL) begin
      mul_start = 1'b1;
    end else if (inv_run && !mul_busy && !inv_wait) begin
      mul_start = 1'b1;
      mul_a = inv_sq ? inv_r : inv_base;
      mul_b = inv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_run <= 1'b0;
      red_run <= 1'b0;
      mul_wait <= 1'b0;
      inv_wait <= 1'b0;
    end else begin
      if (cmd.start) begin
        dst <= cmd.dst;
        unique case (cmd.op)
          OP_LOAD: begin
            m <= cfg_p;
            red_v[0] <= in_px;
            red_v[1] <= in_py;
            red_v[2] <= in_qx;
            red_v[3] <= in_qy;
            red_v[4] <= cfg_a;
            red_v[5] <= cfg_b;
            red_cnt <= RED_BITS'(FIELD_BITS);
            red_run <= 1'b1;
          end
          OP_ADD: rf[cmd.dst] <= addm;
          OP_SUB: rf[cmd.dst] <= subm;
          OP_MOV: rf[cmd.dst] <= va;
          OP_MUL: mul_wait <= 1'b1;
          OP_INV: begin
            inv_run <= 1'b1;
            inv_base <= va;
            inv_r <= FIELD_BITS'(1);
            inv_e <= FIELD_BITS'(m - FIELD_BITS'(2));
            inv_cnt <= CNT_BITS'(FIELD_BITS);
            inv_sq <= 1'b1;
            inv_wait <= 1'b0;
          end
          default: ;
        endcase
      end else if (red_run) begin
        for (int k = 0; k < 6; k++) red_v[k] <= red_n[k];
        red_cnt <= red_cnt - 1'b1;
        if (red_cnt == RED_BITS'(1)) begin
          red_run <= 1'b0;
          rf[R_XP] <= red_n[0];
          rf[R_YP] <= red_n[1];
          rf[R_XQ] <= red_n[2];
          rf[R_YQ] <= red_n[3];
          rf[R_A] <= red_n[4];
          rf[R_B] <= red_n[5];
          rf[R_ONE] <= FIELD_BITS'(1);
          rf[R_K2] <= FIELD_BITS'(2);
          rf[R_K3] <= (m == FIELD_BITS'(3)) ? '0 : FIELD_BITS'(3);
        end
      end else if (mul_wait && !mul_busy) begin
        mul_wait <= 1'b0;
        rf[dst] <= mul_res;
      end else if (inv_run && inv_wait && !mul_busy) begin
        // a multiply just finished
        inv_r <= mul_res;
        inv_wait <= 1'b0;
        if (inv_sq && inv_e[FIELD_BITS-1]) begin
          inv_sq <= 1'b0;
        end else begin
          inv_sq <= 1'b1;
          inv_e <= inv_e << 1;
          inv_cnt <= inv_cnt - 1'b1;
          if (inv_cnt == CNT_BITS'(1)) begin
            inv_run <= 1'b0;
            rf[dst] <= mul_res;
          end
        end
      end else if (mul_start) begin
        // inversion multiply in flight
        inv_wait <= 1'b1;
      end
    end
  end

  assign status.busy = red_run | mul_wait | inv_run | mul_busy | inv_wait;
  assign status.bad_prime = (cfg_p < FIELD_BITS'(3));
  assign status.same_x = (rf[R_XP] == rf[R_XQ]);
  assign status.same_y = (rf[R_YP] == rf[R_YQ]);
  assign status.yp_zero = (rf[R_YP] == '0);
  assign res_x = rf[R_XR];
  assign res_y = rf[R_YR];

endmodule

// ----- rtl/ecpa_ctrl.sv -----
module ecpa_ctrl import ecpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       out_fire,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       in_ready,
  output logic       out_valid,
  output logic       out_inf
);

  localparam int CHORD_START = 0;
  localparam int CHORD_LEN = 7;
  localparam int DBL_START = 7;

  typedef struct packed {
    op_t   op;
    rsel_t dst;
    rsel_t src_a;
    rsel_t src_b;
  } instr_t;

  function automatic instr_t prog(input logic [4:0] pc);
    instr_t i;
    i = '{OP_NONE, R_T0, R_T0, R_T0};
    case (pc)
      // chord
      5'd0:  i = '{OP_SUB, R_T0, R_XQ, R_XP};
      5'd1:  i = '{OP_INV, R_T0, R_T0, R_T0};
      5'd2:  i = '{OP_SUB, R_T1, R_YQ, R_YP};
      5'd3:  i = '{OP_MUL, R_LAM, R_T1, R_T0};
      5'd4:  i = '{OP_MUL, R_T0, R_LAM, R_LAM};
      5'd5:  i = '{OP_SUB, R_T0, R_T0, R_XP};
      5'd6:  i = '{OP_SUB, R_XR, R_T0, R_XQ};
      // doubling
      5'd7:  i = '{OP_MUL, R_T0, R_XP, R_XP};
      5'd8:  i = '{OP_MUL, R_T1, R_T0, R_T0};
      5'd9:  i = '{OP_ADD, R_T2, R_A, R_A};
      5'd10: i = '{OP_MUL, R_T2, R_T2, R_T0};
      5'd11: i = '{OP_SUB, R_T1, R_T1, R_T2};
      5'd12: i = '{OP_ADD, R_T2, R_B, R_B};
      5'd13: i = '{OP_ADD, R_T2, R_T2, R_T2};
      5'd14: i = '{OP_ADD, R_T2, R_T2, R_T2};
      5'd15: i = '{OP_MUL, R_T2, R_T2, R_XP};
      5'd16: i = '{OP_SUB, R_T1, R_T1, R_T2};
      5'd17: i = '{OP_MUL, R_T2, R_B, R_B};
      5'd18: i = '{OP_ADD, R_T1, R_T1, R_T2};
      5'd19: i = '{OP_ADD, R_T3, R_YP, R_YP};
      5'd20: i = '{OP_INV, R_T3, R_T3, R_T3};
      5'd21: i = '{OP_MUL, R_T2, R_T3, R_T3};
      5'd22: i = '{OP_MUL, R_XR, R_T1, R_T2};
      5'd23: i = '{OP_MUL, R_T0, R_K3, R_T0};
      5'd24: i = '{OP_ADD, R_T0, R_T0, R_A};
      5'd25: i = '{OP_MUL, R_LAM, R_T0, R_T3};
      // common tail
      5'd26: i = '{OP_SUB, R_T0, R_XP, R_XR};
      5'd27: i = '{OP_MUL, R_T0, R_LAM, R_T0};
      5'd28: i = '{OP_SUB, R_YR, R_T0, R_YP};
      default: ;
    endcase
    return i;
  endfunction

  localparam logic [4:0] TAIL_PC = 5'd26;
  localparam logic [4:0] LAST_PC = 5'd28;

  state_t     state;
  state_t     state_next;
  logic [4:0] pc;
  logic [4:0] pc_next;
  logic       inf;
  logic       inf_next;
  instr_t     ins;

  assign ins = prog(pc);

  // next state
  always_comb begin
    state_next = state;
    pc_next = pc;
    inf_next = inf;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (status.bad_prime) begin
            inf_next = 1'b1;
            state_next = ST_OUT;
          end else begin
            inf_next = 1'b0;
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: state_next = ST_WAIT;
      ST_CHECK: begin
        if (!status.same_x) begin
          pc_next = 5'(CHORD_START);
          state_next = ST_ISSUE;
        end else if (!status.same_y || status.yp_zero) begin
          inf_next = 1'b1;
          state_next = ST_OUT;
        end else begin
          pc_next = 5'(DBL_START);
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (!status.busy) begin
          if (pc == 5'd31) begin
            state_next = ST_CHECK;
          end else if (pc == LAST_PC) begin
            state_next = ST_OUT;
          end else begin
            pc_next = (pc == 5'(CHORD_START + CHORD_LEN - 1)) ? TAIL_PC : pc + 5'd1;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_OUT: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_IDLE && in_fire) pc_next = 5'd31;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= 5'd31;
      inf <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      inf <= inf_next;
    end
  end

  // outputs
  always_comb begin
    cmd = '{1'b0, OP_NONE, R_T0, R_T0, R_T0};
    unique case (state)
      ST_LOAD: cmd = '{1'b1, OP_LOAD, R_T0, R_T0, R_T0};
      ST_ISSUE: cmd = '{1'b1, ins.op, ins.dst, ins.src_a, ins.src_b};
      default: ;
    endcase
  end

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_inf = inf;

endmodule

// ----- rtl/ec_point_add_prime_field.sv -----
// channel | direction | tdata fields (low bit up)          | tuser
// s_axis  | in        | p_x, p_y, q_x, q_y                 | -
// m_axis  | out       | sum_x, sum_y                       | at_infinity
// cfg     | in        | curve_a=0, curve_b=1, field_prime=2 | -
// after the item is taken the inputs are loaded, reduced and checked;
// a field_prime below 3 gives at_infinity instead
// multiply and inversion (exponent p-2) share the one serial multiplier
// chord: 6 add/sub, 3 multiplies, 1 inversion; doubling: 11, 10 and 1
// one item at a time; s_axis_tready is low until the result is taken
// rst is synchronous, active high, and restores the reset register values
module ec_point_add_prime_field import ecpa_pkg::*; #(
  parameter int FIELD_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // p_x, p_y, q_x, q_y
  input  logic [((4*FIELD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // sum_x, sum_y
  output logic [((2*FIELD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // at_infinity
  output logic                    m_axis_tuser,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_wdata
);

  localparam int OUT_W = ((2*FIELD_BITS+7)/8)*8;

  logic [FIELD_BITS-1:0] curve_a;
  logic [FIELD_BITS-1:0] curve_b;
  logic [FIELD_BITS-1:0] field_prime;
  dp_cmd_t               cmd;
  dp_status_t            status;
  logic                  in_fire;
  logic                  out_fire;
  logic                  out_inf;
  logic [FIELD_BITS-1:0] res_x;
  logic [FIELD_BITS-1:0] res_y;
  logic [FIELD_BITS-1:0] px, py, qx, qy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a <= '0;
      curve_b <= FIELD_BITS'(1);
      field_prime <= FIELD_BITS'(23);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INDEX_BITS'(REG_CURVE_A): curve_a <= cfg_wdata;
        CFG_INDEX_BITS'(REG_CURVE_B): curve_b <= cfg_wdata;
        CFG_INDEX_BITS'(REG_FIELD_PRIME): field_prime <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px <= s_axis_tdata[FIELD_BITS-1:0];
      py <= s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
      qx <= s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
      qy <= s_axis_tdata[4*FIELD_BITS-1:3*FIELD_BITS];
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  ecpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire), .status(status),
    .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_inf(out_inf)
  );

  ecpa_datapath #(.FIELD_BITS(FIELD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_px(px), .in_py(py), .in_qx(qx), .in_qy(qy),
    .cfg_a(curve_a), .cfg_b(curve_b), .cfg_p(field_prime), .status(status),
    .res_x(res_x), .res_y(res_y)
  );

  // result packing, zero at infinity
  assign m_axis_tdata = out_inf ? '0 : OUT_W'({res_y, res_x});
  assign m_axis_tuser = out_inf;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("infinity not zero");

endmodule
